// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules of the peak suppression block.
// Included by bare file name; expands to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property with a synchronous active-low reset as disable.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("clocked property failed");
// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/pns_pkg.sv =====
// Shared constants and types of the 5x5 peak noise suppression block.
// No dependencies; imported by every module of the block.
`default_nettype none

package pns_pkg;

  localparam int MAX_LINE_DEF    = 512;
  localparam int CHARGE_BITS_DEF = 14;

  // Line length register and its saturation floor
  localparam int LEN_W           = 10;
  localparam int MIN_LINE        = 5;
  localparam int LINE_LENGTH_RST = 512;
  localparam int MIN_DROP_RST    = 32;

  // Window geometry and line store slots
  localparam int WIN   = 5;
  localparam int SLOTS = 4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DROP    = 1'b1;

  // Input kind codes
  localparam logic KIND_CELL  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Per-item control that travels with the window column
  typedef struct packed {
    logic           emit;
    logic [WIN-1:0] col_mask;
  } pns_meta_t;

endpackage

`default_nettype wire

// ===== hw/rtl/peak_noise_suppression_5x5.sv =====
// Streaming 5x5 peak noise suppression over a dense charge grid.
// Input: one cell per request on in_*, raster order, pads as lines of
// line_length time bins. in_tuser = kind (flush cell reads as empty); in_tdata
// carries frame_start, charge and is_peak. Output: one request per centre that
// lies on a line of the current frame, trailing the newest cell by two lines
// and two bins. Drain with two lines plus two cells of flush requests.
// Configuration: cfg_we/cfg_addr/cfg_wdata, only while the block is idle.
// Throughput: one cell per cycle unless the output stalls, set by one read and
// one write per line store bank per cycle. A result passes the memory read
// stage, the window stage and the output register before it shows on out_tvalid.
// Reset clears position, line count, pipeline and the fill counters
// of the line store; no clearing pass is needed. When the receiver stalls the
// output register holds, the pipeline keeps filling its empty stages and
// in_tready drops once every stage holds an item.
`default_nettype none
`include "assert_macros.svh"

module peak_noise_suppression_5x5
  import pns_pkg::*;
#(
  parameter int MAX_LINE    = MAX_LINE_DEF,
  parameter int CHARGE_BITS = CHARGE_BITS_DEF,
  localparam int DATA_W = ((CHARGE_BITS + 2 + 7) / 8) * 8,
  localparam int CFG_W  = (CHARGE_BITS > LEN_W) ? CHARGE_BITS : LEN_W
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // in_tdata: frame_start, charge, is_peak (from bit 0 up)
  input  wire logic [DATA_W-1:0]    in_tdata,
  // in_tuser: kind
  input  wire logic                 in_tuser,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // out_tdata: keep, was_peak, centre_charge (from bit 0 up)
  output logic      [DATA_W-1:0]    out_tdata,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int CELL_W = CHARGE_BITS + 1;
  localparam int COL_W  = $clog2(MAX_LINE);
  localparam int HW_W   = $clog2(MAX_LINE + 1);
  localparam int EL_W   = (HW_W > LEN_W) ? HW_W : LEN_W;

  // Configuration
  logic [LEN_W-1:0]       line_length_r;
  logic [CHARGE_BITS-1:0] min_drop_r;

  // Scan position
  logic [COL_W-1:0] pos_r, pos_nxt;
  logic [2:0]       lines_r, lines_nxt;
  logic [1:0]       slot_r, slot_nxt;

  // Pipeline
  logic             a_valid_r, b_valid_r, out_valid_r;
  pns_meta_t        a_meta_r, meta_nxt;
  logic [SLOTS-1:0] a_row_en_r, row_en_nxt;
  logic [CELL_W-1:0] a_cell_r, in_cell;
  logic [DATA_W-1:0] out_data_r;

  logic in_fire, a_adv, b_adv, b_free, out_free;
  logic fs;
  logic [COL_W-1:0] pos;
  logic [2:0]       ls;
  logic [EL_W-1:0]  ll_ext, eff_len, pos_inc;

  logic [SLOTS-1:0][CELL_W-1:0] store_rows;
  logic [WIN-1:0][CELL_W-1:0]   col_cells;

  logic                   b_emit, b_keep, b_was_peak;
  logic [CHARGE_BITS-1:0] b_charge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= LEN_W'(LINE_LENGTH_RST);
      min_drop_r    <= CHARGE_BITS'(MIN_DROP_RST);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LINE_LENGTH: line_length_r <= cfg_wdata[LEN_W-1:0];
        REG_MIN_DROP:    min_drop_r    <= cfg_wdata[CHARGE_BITS-1:0];
        default:         ;
      endcase
    end
  end

  // Handshake chain: each stage advances when the next one is free
  assign out_free  = !out_valid_r || out_tready;
  assign b_adv     = b_valid_r && (!b_emit || out_free);
  assign b_free    = !b_valid_r || b_adv;
  assign a_adv     = a_valid_r && b_free;
  assign in_tready = !a_valid_r || a_adv;
  assign in_fire   = in_tvalid && in_tready;

  assign fs      = in_tdata[0];
  assign pos     = fs ? '0 : pos_r;
  assign ls      = fs ? '0 : lines_r;
  assign in_cell = (in_tuser == KIND_FLUSH) ? '0
                 : {in_tdata[CHARGE_BITS+1], in_tdata[CHARGE_BITS:1]};

  always_comb begin
    ll_ext = EL_W'(line_length_r);
    if (ll_ext < EL_W'(MIN_LINE)) begin
      eff_len = EL_W'(MIN_LINE);
    end else if (ll_ext > EL_W'(MAX_LINE)) begin
      eff_len = EL_W'(MAX_LINE);
    end else begin
      eff_len = ll_ext;
    end
    pos_inc = EL_W'(pos) + EL_W'(1);

    if (pos_inc >= eff_len) begin
      pos_nxt   = '0;
      lines_nxt = (ls < 3'd4) ? ls + 3'd1 : ls;
      slot_nxt  = slot_r + 2'd1;
    end else begin
      pos_nxt   = COL_W'(pos_inc);
      lines_nxt = ls;
      slot_nxt  = slot_r;
    end

    // At the first two bins the centre is the tail of an older line
    priority if (pos == '0) begin
      meta_nxt.emit     = ls >= 3'd3;
      meta_nxt.col_mask = 5'b01111;
    end else if (pos == COL_W'(1)) begin
      meta_nxt.emit     = ls >= 3'd3;
      meta_nxt.col_mask = 5'b00111;
    end else if (pos == COL_W'(2)) begin
      meta_nxt.emit     = ls >= 3'd2;
      meta_nxt.col_mask = 5'b11100;
    end else if (pos == COL_W'(3)) begin
      meta_nxt.emit     = ls >= 3'd2;
      meta_nxt.col_mask = 5'b11110;
    end else begin
      meta_nxt.emit     = ls >= 3'd2;
      meta_nxt.col_mask = 5'b11111;
    end

    // Row r needs 4-r completed lines in this frame
    row_en_nxt = {ls >= 3'd1, ls >= 3'd2, ls >= 3'd3, ls >= 3'd4};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      lines_r <= '0;
      slot_r  <= '0;
    end else if (in_fire) begin
      pos_r   <= pos_nxt;
      lines_r <= lines_nxt;
      slot_r  <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        a_valid_r <= 1'b1;
      end else if (a_adv) begin
        a_valid_r <= 1'b0;
      end
      if (a_adv) begin
        b_valid_r <= 1'b1;
      end else if (b_adv) begin
        b_valid_r <= 1'b0;
      end
      if (b_adv && b_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_meta_r   <= meta_nxt;
      a_row_en_r <= row_en_nxt;
      a_cell_r   <= in_cell;
    end
    if (b_adv && b_emit) begin
      out_data_r <= DATA_W'({b_charge, b_was_peak, b_keep});
    end
  end

  pns_line_store #(
    .MAX_LINE    (MAX_LINE),
    .CHARGE_BITS (CHARGE_BITS)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (in_fire),
    .col   (pos),
    .slot  (slot_r),
    .wdata (in_cell),
    .rows  (store_rows)
  );

  always_comb begin
    for (int r = 0; r < SLOTS; r++) begin
      col_cells[r] = a_row_en_r[r] ? store_rows[r] : '0;
    end
    col_cells[WIN-1] = a_cell_r;
  end

  pns_suppress #(
    .CHARGE_BITS (CHARGE_BITS)
  ) u_suppress (
    .clk           (clk),
    .rst_n         (rst_n),
    .shift_en      (a_adv),
    .col_cells     (col_cells),
    .meta_in       (a_meta_r),
    .min_drop      (min_drop_r),
    .emit          (b_emit),
    .keep          (b_keep),
    .was_peak      (b_was_peak),
    .centre_charge (b_charge)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `ASSERT_CLK(a_accept_fills_a, clk, rst_n, in_fire |=> a_valid_r)
  `ASSERT_CLK(a_no_overwrite, clk, rst_n, a_valid_r && !a_adv |-> !in_tready)
  `ASSERT_CLK(a_emit_loads_out, clk, rst_n, b_adv && b_emit |=> out_valid_r)
  `ASSERT_NEVER(a_lines_bound, clk, rst_n, lines_r > 3'd4)

endmodule

`default_nettype wire

// ===== hw/rtl/pns_line_store.sv =====
// Four-line store: one synchronous bank per line slot, read-first, registered read.
// Per-bank fill counters make never-written entries read as empty. Uses pns_pkg.
`default_nettype none
`include "assert_macros.svh"

module pns_line_store
  import pns_pkg::*;
#(
  parameter int MAX_LINE    = MAX_LINE_DEF,
  parameter int CHARGE_BITS = CHARGE_BITS_DEF,
  localparam int CELL_W = CHARGE_BITS + 1,
  localparam int COL_W  = $clog2(MAX_LINE),
  localparam int HW_W   = $clog2(MAX_LINE + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic [COL_W-1:0]              col,
  input  wire logic [1:0]                    slot,
  input  wire logic [CELL_W-1:0]             wdata,
  output logic      [SLOTS-1:0][CELL_W-1:0]  rows
);

  logic [HW_W-1:0]   fill_r  [SLOTS];
  logic [SLOTS-1:0]  fill_ok_r;
  logic [1:0]        base_r;
  logic [CELL_W-1:0] bank_q  [SLOTS];

  for (genvar b = 0; b < SLOTS; b++) begin : g_bank
    logic [CELL_W-1:0] mem [MAX_LINE];
    logic [CELL_W-1:0] rd_r;

    // Read-first: the oldest line is read at the address being overwritten
    always_ff @(posedge clk) begin
      if (en) begin
        rd_r <= mem[col];
        if (slot == 2'(b)) begin
          mem[col] <= wdata;
        end
      end
    end

    assign bank_q[b] = rd_r;
  end

  // Each slot is written from address zero upward, so the written part is a prefix
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < SLOTS; b++) begin
        fill_r[b] <= '0;
      end
    end else if (en) begin
      for (int b = 0; b < SLOTS; b++) begin
        if (slot == 2'(b) && HW_W'(col) == fill_r[b]) begin
          fill_r[b] <= fill_r[b] + HW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base_r <= slot;
      for (int b = 0; b < SLOTS; b++) begin
        fill_ok_r[b] <= HW_W'(col) < fill_r[b];
      end
    end
  end

  // Row r holds the line 4-r back: bank slot+r
  always_comb begin
    logic [1:0] bsel;
    for (int r = 0; r < SLOTS; r++) begin
      bsel    = base_r + 2'(r);
      rows[r] = fill_ok_r[bsel] ? bank_q[bsel] : '0;
    end
  end

  `ASSERT_NEVER(a_write_past_fill, clk, rst_n, en && (HW_W'(col) > fill_r[slot]))
  `ASSERT_NEVER(a_fill_bound, clk, rst_n, fill_r[slot] > HW_W'(MAX_LINE))
  `ASSERT_CLK(a_fill_grows, clk, rst_n,
    en && (HW_W'(col) == fill_r[slot]) |=> fill_r[$past(slot)] != $past(fill_r[slot]))

endmodule

`default_nettype wire

// ===== hw/rtl/pns_suppress.sv =====
// 5x5 window registers and the sixteen parallel ring compares.
// Shifts in one column per item; result is combinational from the window. Uses pns_pkg.
`default_nettype none

module pns_suppress
  import pns_pkg::*;
#(
  parameter int CHARGE_BITS = CHARGE_BITS_DEF,
  localparam int CELL_W = CHARGE_BITS + 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         shift_en,
  input  wire logic [WIN-1:0][CELL_W-1:0]   col_cells,
  input  wire pns_meta_t                    meta_in,
  input  wire logic [CHARGE_BITS-1:0]       min_drop,
  output logic                              emit,
  output logic                              keep,
  output logic                              was_peak,
  output logic      [CHARGE_BITS-1:0]       centre_charge
);

  logic [CELL_W-1:0] win_r [WIN][WIN];
  pns_meta_t         meta_r;

  // Shift left along time, newest column enters on the right
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int r = 0; r < WIN; r++) begin
        for (int t = 0; t < WIN - 1; t++) begin
          win_r[r][t] <= win_r[r][t + 1];
        end
        win_r[r][WIN-1] <= col_cells[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r <= '0;
    end else if (shift_en) begin
      meta_r <= meta_in;
    end
  end

  always_comb begin
    logic                   sup;
    logic [CHARGE_BITS-1:0] cq;
    logic [CELL_W-1:0]      oc;
    logic [CELL_W-1:0]      bc;
    int                     br;
    int                     bt;
    sup = 1'b0;
    cq  = win_r[2][2][CHARGE_BITS-1:0];
    for (int r = 0; r < WIN; r++) begin
      for (int t = 0; t < WIN; t++) begin
        // Between cell: offsets clamped into the inner 3x3
        br = (r < 1) ? 1 : ((r > 3) ? 3 : r);
        bt = (t < 1) ? 1 : ((t > 3) ? 3 : t);
        oc = meta_r.col_mask[t]  ? win_r[r][t]   : '0;
        bc = meta_r.col_mask[bt] ? win_r[br][bt] : '0;
        if ((r == 0 || r == WIN - 1 || t == 0 || t == WIN - 1) &&
            oc[CHARGE_BITS] && (oc[CHARGE_BITS-1:0] > cq) &&
            ({1'b0, cq} >= ({1'b0, bc[CHARGE_BITS-1:0]} + {1'b0, min_drop}))) begin
          sup = 1'b1;
        end
      end
    end
    emit          = meta_r.emit;
    was_peak      = win_r[2][2][CHARGE_BITS];
    keep          = win_r[2][2][CHARGE_BITS] && !sup;
    centre_charge = cq;
  end

endmodule

`default_nettype wire
